// ----- hdl/mpe_pkg.sv -----
`timescale 1ns / 1ps
package mpe_pkg;

    // Internal number: value = (neg ? -1 : 1) * m * 2^k, m in [2^62, 2^63) or zero
    typedef struct packed {
        logic [63:0]        m;
        logic signed [11:0] k;
        logic               neg;
    } fnum_t;

    localparam fnum_t FNUM_ZERO = '{m: 64'd0, k: 12'sd0, neg: 1'b0};

    // Opcodes
    localparam logic [1:0] OP_VALUE  = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_SECOND = 2'd2;
    localparam logic [1:0] OP_UNDEF  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_WELL_DEPTH   = 3'd0;
    localparam logic [2:0] REG_DECAY_RATE   = 3'd1;
    localparam logic [2:0] REG_EQUIL_DIST   = 3'd2;
    localparam logic [2:0] REG_OFFSET_CONST = 3'd3;
    localparam logic [2:0] REG_OFFSET_SLOPE = 3'd4;
    localparam logic [2:0] REG_CUTOFF       = 3'd5;

    // Register reset values
    localparam logic [31:0] RST_WELL_DEPTH   = 32'd63350768;
    localparam logic [31:0] RST_DECAY_RATE   = 32'd24929265;
    localparam logic [31:0] RST_EQUIL_DIST   = 32'd35527433;
    localparam logic [31:0] RST_OFFSET_CONST = 32'd7053588;
    localparam logic [31:0] RST_OFFSET_SLOPE = 32'hFFEEB962;
    localparam logic [30:0] RST_CUTOFF       = 31'd93197435;

    // Arithmetic constants
    localparam logic signed [63:0] LOG2E_Q28 = 64'sd387270501;
    localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
    localparam logic [63:0]        T_LIMIT   = 64'd1 << 34;
    localparam logic [63:0]        RES_LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        RES_LIM_NEG = 64'h8000_0000_0000_0000;

    // Cycles for the coefficient chain to settle after a register write
    localparam logic [3:0] SETTLE_CYCLES = 4'd11;

endpackage

// ----- hdl/mpe_fmul.sv -----
`timescale 1ns / 1ps
module mpe_fmul import mpe_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  fnum_t a,
    input  fnum_t b,
    output fnum_t y
);

    logic [63:0]        p00_reg;
    logic [62:0]        p01_reg;
    logic [62:0]        p10_reg;
    logic [61:0]        p11_reg;
    logic               z1_reg;
    logic signed [11:0] k1_reg;
    logic               n1_reg;

    logic [125:0]       prod_next;
    logic [63:0]        r2_reg;
    logic               z2_reg;
    logic signed [11:0] k2_reg;
    logic               n2_reg;

    fnum_t              y_reg;

    // Stage 1: four partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= {32'd0, a.m[31:0]} * {32'd0, b.m[31:0]};
            p01_reg <= {31'd0, a.m[31:0]} * {32'd0, b.m[62:32]};
            p10_reg <= {32'd0, a.m[62:32]} * {31'd0, b.m[31:0]};
            p11_reg <= {31'd0, a.m[62:32]} * {31'd0, b.m[62:32]};
            z1_reg  <= (a.m == 64'd0) || (b.m == 64'd0);
            k1_reg  <= a.k + b.k + 12'sd62;
            n1_reg  <= a.neg ^ b.neg;
        end
    end

    // Stage 2: sum partials, keep the top 64 bits
    always_comb begin
        prod_next = {p11_reg, 64'd0} + {31'd0, p01_reg, 32'd0} + {31'd0, p10_reg, 32'd0}
                  + {62'd0, p00_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg <= prod_next[125:62];
            z2_reg <= z1_reg;
            k2_reg <= k1_reg;
            n2_reg <= n1_reg;
        end
    end

    // Stage 3: one-bit normalise
    always_ff @(posedge aclk) begin
        if (en) begin
            if (z2_reg) begin
                y_reg <= FNUM_ZERO;
            end else if (r2_reg[63]) begin
                y_reg <= '{m: {1'b0, r2_reg[63:1]}, k: k2_reg + 12'sd1, neg: n2_reg};
            end else begin
                y_reg <= '{m: r2_reg, k: k2_reg, neg: n2_reg};
            end
        end
    end

    assign y = y_reg;

endmodule

// ----- hdl/mpe_fadd.sv -----
`timescale 1ns / 1ps
module mpe_fadd import mpe_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  fnum_t a,
    input  fnum_t b,
    output fnum_t y
);

    logic               swap;
    fnum_t              big;
    fnum_t              sml;
    logic signed [12:0] kd;
    logic [63:0]        bm_next;

    logic [63:0]        am_reg;
    logic [63:0]        bm_reg;
    logic signed [11:0] k1_reg;
    logic               sa_reg;
    logic               sb_reg;

    logic [63:0]        s_next;
    logic               n_next;
    logic [63:0]        s2_reg;
    logic signed [11:0] k2_reg;
    logic               n2_reg;

    logic [7:0]         nz;
    logic [3:0]         blz [0:7];
    logic [6:0]         lz_next;
    logic [63:0]        s3_reg;
    logic signed [11:0] k3_reg;
    logic               n3_reg;
    logic [6:0]         lz3_reg;

    logic [5:0]         sh;
    fnum_t              y_reg;

    // Stage 1: order by exponent, align the smaller operand
    always_comb begin
        swap = (a.m == 64'd0) || ((b.m != 64'd0) && (a.k < b.k));
        big  = swap ? b : a;
        sml  = swap ? a : b;
        kd   = 13'(big.k) - 13'(sml.k);
        if ((sml.m == 64'd0) || (kd >= 13'sd64)) begin
            bm_next = 64'd0;
        end else begin
            bm_next = sml.m >> kd[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg <= big.m;
            bm_reg <= bm_next;
            k1_reg <= big.k;
            sa_reg <= big.neg;
            sb_reg <= sml.neg;
        end
    end

    // Stage 2: add or subtract magnitudes
    always_comb begin
        if (sa_reg == sb_reg) begin
            s_next = am_reg + bm_reg;
            n_next = sa_reg;
        end else if (am_reg >= bm_reg) begin
            s_next = am_reg - bm_reg;
            n_next = sa_reg;
        end else begin
            s_next = bm_reg - am_reg;
            n_next = sb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s_next;
            k2_reg <= k1_reg;
            n2_reg <= n_next;
        end
    end

    // Stage 3: leading-zero count, per byte then across bytes
    always_comb begin
        for (int bi = 0; bi < 8; bi++) begin
            nz[bi]  = |s2_reg[8*bi +: 8];
            blz[bi] = 4'd8;
            for (int i = 0; i < 8; i++) begin
                if (s2_reg[8*bi + i]) blz[bi] = 4'(7 - i);
            end
        end
        lz_next = 7'd64;
        for (int bi = 0; bi < 8; bi++) begin
            if (nz[bi]) lz_next = 7'((7 - bi) * 8) + {3'd0, blz[bi]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg  <= s2_reg;
            k3_reg  <= k2_reg;
            n3_reg  <= n2_reg;
            lz3_reg <= lz_next;
        end
    end

    // Stage 4: normalising shift
    assign sh = 6'(lz3_reg - 7'd1);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s3_reg == 64'd0) begin
                y_reg <= FNUM_ZERO;
            end else if (lz3_reg == 7'd0) begin
                y_reg <= '{m: {1'b0, s3_reg[63:1]}, k: k3_reg + 12'sd1, neg: n3_reg};
            end else begin
                y_reg <= '{m: s3_reg << sh, k: k3_reg - $signed({6'd0, sh}), neg: n3_reg};
            end
        end
    end

    assign y = y_reg;

endmodule

// ----- hdl/morse_pair_potential_eval_core.sv -----
`timescale 1ns / 1ps
// Morse pair potential evaluator with linear cutoff shift.
// Input stream: one beat per neighbour distance. s_tdata[31:0] is the distance
// (unsigned Q4.28), s_tuser[1:0] the opcode (value, first or second derivative).
// Result stream: m_tdata[63:0] is the signed Q24.40 result, m_tuser[0] is high
// when the result was clipped. A distance beyond the cutoff, or the undefined
// opcode, gives zero.
// Throughput: one beat per cycle while s_tready is high. The path from input beat
// to result beat runs through the 10-step exp series (three stages each) and the
// chain of pipelined multiply and add units that follow it.
// Registers are written over the APB port. After reset and after every register
// write s_tready stays low while the coefficients derived from the registers
// run through their own multiply and add units.
// Reset is synchronous, active low; it drops all beats in flight and loads the
// register reset values. When the receiver stalls, a finished result waits in
// the output register and the pipeline keeps running until its last stage holds
// a beat too; then the whole pipeline holds and s_tready drops.
module morse_pair_potential_eval_core import mpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat: s_tdata [31:0] distance; s_tuser [1:0] opcode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    // Result beat: m_tdata [63:0] result_value; m_tuser [0] saturated
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [0:0]  m_tuser,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic fnum_t fn_dbl(input fnum_t v);
        fnum_t r;
        r = v;
        if (v.m != 64'd0) r.k = v.k + 12'sd1;
        return r;
    endfunction

    function automatic fnum_t fn_neg(input fnum_t v);
        fnum_t r;
        r = v;
        if (v.m != 64'd0) r.neg = ~v.neg;
        return r;
    endfunction

    // Fixed-point form of a signed 32-bit register with 24 fraction bits, not yet normalised
    function automatic fnum_t fn_fix32(input logic [31:0] v);
        fnum_t r;
        r.neg = v[31];
        r.m   = v[31] ? (64'd0 - {{32{v[31]}}, v}) : {32'd0, v};
        r.k   = -12'sd24;
        return r;
    endfunction

    // Convert to signed fixed point, clamping; returns {clip, value}
    function automatic logic [64:0] to_fix(input fnum_t v, input logic signed [13:0] frac,
                                           input logic [63:0] lim_pos,
                                           input logic [63:0] lim_neg);
        logic signed [13:0] s;
        logic [63:0]        mag;
        logic [63:0]        lim;
        logic [63:0]        val;
        logic               over;
        logic               clip;
        s    = 14'(v.k) + frac;
        over = 1'b0;
        mag  = 64'd0;
        if (s >= 14'sd2) begin
            over = 1'b1;
        end else if (s == 14'sd1) begin
            mag = {v.m[62:0], 1'b0};
        end else if (s <= -14'sd64) begin
            mag = 64'd0;
        end else begin
            mag = v.m >> 6'(-s);
        end
        lim  = v.neg ? lim_neg : lim_pos;
        clip = over || (mag > lim);
        if (clip) mag = lim;
        val = v.neg ? (64'd0 - mag) : mag;
        if (v.m == 64'd0) begin
            val  = 64'd0;
            clip = 1'b0;
        end
        return {clip, val};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] wd_reg;
    logic [31:0] dr_reg;
    logic [31:0] ed_reg;
    logic [31:0] oc_reg;
    logic [31:0] os_reg;
    logic [30:0] cr_reg;
    logic [3:0]  settle_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wd_reg <= RST_WELL_DEPTH;
            dr_reg <= RST_DECAY_RATE;
            ed_reg <= RST_EQUIL_DIST;
            oc_reg <= RST_OFFSET_CONST;
            os_reg <= RST_OFFSET_SLOPE;
            cr_reg <= RST_CUTOFF;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_WELL_DEPTH:   wd_reg <= pwdata;
                REG_DECAY_RATE:   dr_reg <= pwdata;
                REG_EQUIL_DIST:   ed_reg <= pwdata;
                REG_OFFSET_CONST: oc_reg <= pwdata;
                REG_OFFSET_SLOPE: os_reg <= pwdata;
                REG_CUTOFF:       cr_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_WELL_DEPTH:   prdata = wd_reg;
            REG_DECAY_RATE:   prdata = dr_reg;
            REG_EQUIL_DIST:   prdata = ed_reg;
            REG_OFFSET_CONST: prdata = oc_reg;
            REG_OFFSET_SLOPE: prdata = os_reg;
            REG_CUTOFF:       prdata = {1'b0, cr_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Hold input off while the coefficient chain settles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (cfg_wr) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != 4'd0) begin
            settle_reg <= settle_reg - 4'd1;
        end
    end

    // ------------------------------------------------------------------
    // Coefficients derived from the registers (free-running)
    // ------------------------------------------------------------------
    fnum_t dn;
    fnum_t an;
    fnum_t q0n;
    fnum_t q1n;
    fnum_t ad_prod;
    fnum_t aa_prod;
    fnum_t aad_prod;
    fnum_t coef1;
    fnum_t coef2;

    mpe_fadd u_cf_d  (.aclk(aclk), .en(1'b1), .a(fn_fix32(wd_reg)), .b(FNUM_ZERO), .y(dn));
    mpe_fadd u_cf_a  (.aclk(aclk), .en(1'b1), .a(fn_fix32(dr_reg)), .b(FNUM_ZERO), .y(an));
    mpe_fadd u_cf_q0 (.aclk(aclk), .en(1'b1), .a(fn_fix32(oc_reg)), .b(FNUM_ZERO), .y(q0n));
    mpe_fadd u_cf_q1 (.aclk(aclk), .en(1'b1), .a(fn_fix32(os_reg)), .b(FNUM_ZERO), .y(q1n));
    mpe_fmul u_cf_ad  (.aclk(aclk), .en(1'b1), .a(an), .b(dn), .y(ad_prod));
    mpe_fmul u_cf_aa  (.aclk(aclk), .en(1'b1), .a(an), .b(an), .y(aa_prod));
    mpe_fmul u_cf_aad (.aclk(aclk), .en(1'b1), .a(aa_prod), .b(dn), .y(aad_prod));

    assign coef1 = fn_dbl(ad_prod);
    assign coef2 = fn_dbl(aad_prod);

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    localparam int LAST = 59;

    logic        en;
    logic        accept;
    logic        vld_reg [0:LAST];
    logic [1:0]  op_line [0:LAST-1];
    logic        kill_line [0:LAST-1];

    // Stall only when the output waits and the last stage holds a beat
    assign en       = !(m_tvalid && !m_tready && vld_reg[LAST]);
    assign s_tready = en && (settle_reg == 4'd0);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LAST; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= accept;
            for (int i = 1; i <= LAST; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the beat, form R - x and the cutoff test
    // ------------------------------------------------------------------
    logic signed [36:0] d_next;
    logic signed [36:0] d_reg;
    logic [31:0]        x_reg;
    fnum_t              dfix_in;
    fnum_t              xfix_in;

    assign d_next = $signed({ed_reg[31], ed_reg, 4'd0}) - $signed({5'd0, s_tdata});

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg        <= s_tdata;
            d_reg        <= d_next;
            op_line[0]   <= s_tuser;
            kill_line[0] <= (s_tuser == OP_UNDEF) || ({4'd0, s_tdata} > {cr_reg, 4'd0});
            for (int i = 1; i < LAST; i++) begin
                op_line[i]   <= op_line[i-1];
                kill_line[i] <= kill_line[i-1];
            end
        end
    end

    always_comb begin
        dfix_in.neg = d_reg[36];
        dfix_in.m   = d_reg[36] ? (64'd0 - 64'(d_reg)) : 64'(d_reg);
        dfix_in.k   = -12'sd28;
        xfix_in.neg = 1'b0;
        xfix_in.m   = {32'd0, x_reg};
        xfix_in.k   = -12'sd28;
    end

    // Stages 1-4: normalise; stages 5-7: products
    fnum_t dn_item;
    fnum_t xn_item;
    fnum_t adx;
    fnum_t q1x;

    mpe_fadd u_norm_d (.aclk(aclk), .en(en), .a(dfix_in), .b(FNUM_ZERO), .y(dn_item));
    mpe_fadd u_norm_x (.aclk(aclk), .en(en), .a(xfix_in), .b(FNUM_ZERO), .y(xn_item));
    mpe_fmul u_mul_t  (.aclk(aclk), .en(en), .a(an),  .b(dn_item), .y(adx));
    mpe_fmul u_mul_qx (.aclk(aclk), .en(en), .a(q1n), .b(xn_item), .y(q1x));

    // Delay q1*x until the last add (stage 54)
    localparam int QX_DEPTH = 47;
    fnum_t q1x_line [0:QX_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            q1x_line[0] <= q1x;
            for (int i = 1; i < QX_DEPTH; i++) q1x_line[i] <= q1x_line[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stages 8-10: exponent argument, split into 2^k * 2^f
    // ------------------------------------------------------------------
    logic [64:0]        t_fix;
    logic signed [35:0] t_reg;
    logic signed [63:0] u_reg;
    logic [61:0]        y_prod;
    logic [29:0]        y_reg;
    logic signed [7:0]  k_reg;

    assign t_fix  = to_fix(adx, 14'sd28, T_LIMIT, T_LIMIT);
    assign y_prod = {32'd0, u_reg[55:26]} * {30'd0, LN2_Q32};

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= $signed(t_fix[35:0]);
            u_reg <= 64'(t_reg) * LOG2E_Q28;
            y_reg <= y_prod[61:32];
            k_reg <= u_reg[63:56];
        end
    end

    // ------------------------------------------------------------------
    // Stages 11-40: series for 2^f, one Horner step per three stages
    // ------------------------------------------------------------------
    logic [31:0]       hp [0:10];
    logic [29:0]       hy [0:10];
    logic signed [7:0] hk [0:10];

    assign hp[0] = 32'd1 << 30;
    assign hy[0] = y_reg;
    assign hk[0] = k_reg;

    for (genvar j = 0; j < 10; j++) begin : g_horner
        localparam int          N  = 10 - j;
        localparam logic [35:0] NC = 36'(N);
        localparam logic [35:0] MC = 36'((64'd1 << 35) / N);

        logic [61:0]       prod_reg;
        logic [29:0]       ya_reg;
        logic signed [7:0] ka_reg;
        logic [67:0]       qm_next;
        logic [31:0]       v_reg;
        logic [31:0]       q0_reg;
        logic [29:0]       yb_reg;
        logic signed [7:0] kb_reg;
        logic [35:0]       r_next;
        logic [31:0]       q_next;
        logic [31:0]       p_reg;
        logic [29:0]       yc_reg;
        logic signed [7:0] kc_reg;

        // Quotient estimate by reciprocal: exact or one short
        assign qm_next = {36'd0, prod_reg[61:30]} * {32'd0, MC};
        assign r_next  = {4'd0, v_reg} - ({4'd0, q0_reg} * NC);
        assign q_next  = (r_next >= NC) ? (q0_reg + 32'd1) : q0_reg;

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg <= {30'd0, hp[j]} * {32'd0, hy[j]};
                ya_reg   <= hy[j];
                ka_reg   <= hk[j];
                v_reg    <= prod_reg[61:30];
                q0_reg   <= qm_next[66:35];
                yb_reg   <= ya_reg;
                kb_reg   <= ka_reg;
                p_reg    <= (32'd1 << 30) + q_next;
                yc_reg   <= yb_reg;
                kc_reg   <= kb_reg;
            end
        end

        assign hp[j+1] = p_reg;
        assign hy[j+1] = yc_reg;
        assign hk[j+1] = kc_reg;
    end

    // ------------------------------------------------------------------
    // Stages 41-43: e and e^2
    // ------------------------------------------------------------------
    fnum_t e_val;
    fnum_t e_line [0:2];
    fnum_t e2;

    always_comb begin
        e_val.m   = {1'b0, hp[10][30:0], 32'd0};
        e_val.k   = 12'(hk[10]) - 12'sd62;
        e_val.neg = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_line[0] <= e_val;
            e_line[1] <= e_line[0];
            e_line[2] <= e_line[1];
        end
    end

    mpe_fmul u_mul_e2 (.aclk(aclk), .en(en), .a(e_val), .b(e_val), .y(e2));

    // ------------------------------------------------------------------
    // Stages 44-58: bracket, coefficient, offsets
    // ------------------------------------------------------------------
    fnum_t br_a;
    fnum_t br_b;
    fnum_t br;
    fnum_t cf_sel;
    fnum_t scaled;
    fnum_t off1_sel;
    fnum_t sum1;
    fnum_t off2_sel;
    fnum_t sum2;

    always_comb begin
        case (op_line[43])
            OP_VALUE: begin
                br_a = e2;
                br_b = fn_neg(fn_dbl(e_line[2]));
            end
            OP_FIRST: begin
                br_a = e_line[2];
                br_b = fn_neg(e2);
            end
            default: begin
                br_a = fn_dbl(e2);
                br_b = fn_neg(e_line[2]);
            end
        endcase
    end

    mpe_fadd u_add_br (.aclk(aclk), .en(en), .a(br_a), .b(br_b), .y(br));

    always_comb begin
        case (op_line[47])
            OP_VALUE: cf_sel = dn;
            OP_FIRST: cf_sel = coef1;
            default:  cf_sel = coef2;
        endcase
    end

    mpe_fmul u_mul_cf (.aclk(aclk), .en(en), .a(cf_sel), .b(br), .y(scaled));

    always_comb begin
        case (op_line[50])
            OP_VALUE: off1_sel = q0n;
            OP_FIRST: off1_sel = q1n;
            default:  off1_sel = FNUM_ZERO;
        endcase
    end

    mpe_fadd u_add_o1 (.aclk(aclk), .en(en), .a(scaled), .b(off1_sel), .y(sum1));

    assign off2_sel = (op_line[54] == OP_VALUE) ? q1x_line[QX_DEPTH-1] : FNUM_ZERO;

    mpe_fadd u_add_o2 (.aclk(aclk), .en(en), .a(sum1), .b(off2_sel), .y(sum2));

    // ------------------------------------------------------------------
    // Stage 59: convert to Q24.40 with saturation
    // ------------------------------------------------------------------
    logic [64:0] res_fix;
    logic [63:0] res_reg;
    logic        sat_reg;

    assign res_fix = to_fix(sum2, 14'sd40, RES_LIM_POS, RES_LIM_NEG);

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= kill_line[LAST-1] ? 64'd0 : res_fix[63:0];
            sat_reg <= kill_line[LAST-1] ? 1'b0 : res_fix[64];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        out_vld_reg;
    logic [63:0] out_data_reg;
    logic        out_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en && vld_reg[LAST]) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[LAST]) begin
            out_data_reg <= res_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import mpe_pkg::*;

    // Mantissa-exponent number used by the predictor: value = +-m * 2^k
    typedef struct {
        logic [63:0] m;
        int          k;
        bit          neg;
    } mnum_t;

    typedef struct {
        logic [63:0] value;
        bit          sat;
    } morse_res_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] distance
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] result_value
    logic [0:0]  m_tuser;   // [0] saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    morse_pair_potential_eval_core dut (.*);

    always #4 aclk = ~aclk;

    // Local copy of the register file
    logic [31:0] well_depth, decay_rate, equil_dist, offset_const, offset_slope;
    logic [30:0] cutoff;

    morse_res_t expected_results[$];

    int errors = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int sat_seen = 0;
    int beyond_cut = 0;
    int reg_writes = 0;
    int idle_cycles = 0;

    // Sender and receiver pacing
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    // ---------------------------------------------------------------
    // Predictor arithmetic
    // ---------------------------------------------------------------
    function automatic mnum_t norm(logic [63:0] m, int k, bit neg);
        mnum_t r;
        r = '{m: 64'd0, k: 0, neg: 1'b0};
        if (m == 64'd0) return r;
        while (m[63]) begin
            m = m >> 1;
            k++;
        end
        while (!m[62]) begin
            m = m << 1;
            k--;
        end
        r = '{m: m, k: k, neg: neg};
        return r;
    endfunction

    function automatic mnum_t from_fixed(longint v, int frac);
        logic [63:0] mag;
        mag = (v < 0) ? 64'd0 - 64'(v) : 64'(v);
        return norm(mag, -frac, v < 0);
    endfunction

    function automatic mnum_t negate(mnum_t a);
        if (a.m != 0) a.neg = !a.neg;
        return a;
    endfunction

    function automatic mnum_t twice(mnum_t a);
        if (a.m != 0) a.k++;
        return a;
    endfunction

    function automatic mnum_t mul(mnum_t a, mnum_t b);
        logic [127:0] p;
        if (a.m == 0 || b.m == 0) return norm(64'd0, 0, 1'b0);
        p = {64'd0, a.m} * {64'd0, b.m};
        return norm(p[125:62], a.k + b.k + 62, a.neg != b.neg);
    endfunction

    function automatic mnum_t add(mnum_t a, mnum_t b);
        mnum_t       sw;
        int          d;
        logic [63:0] bm;
        if (a.m == 0) return b;
        if (b.m == 0) return a;
        if (a.k < b.k) begin
            sw = a;
            a = b;
            b = sw;
        end
        d = a.k - b.k;
        bm = (d >= 64) ? 64'd0 : (b.m >> d);
        if (a.neg == b.neg) return norm(a.m + bm, a.k, a.neg);
        if (a.m >= bm) return norm(a.m - bm, a.k, a.neg);
        return norm(bm - a.m, a.k, b.neg);
    endfunction

    // Truncate towards zero into a two's complement word, clamping the magnitude
    function automatic logic [63:0] to_fixed(mnum_t v, int frac, logic [63:0] lim_pos,
                                             logic [63:0] lim_neg, output bit clip);
        int          s;
        logic [63:0] mag;
        logic [63:0] lim;
        bit          over;
        clip = 1'b0;
        over = 1'b0;
        mag = 64'd0;
        if (v.m == 0) return 64'd0;
        s = v.k + frac;
        if (s >= 2) over = 1'b1;
        else if (s == 1) mag = v.m << 1;
        else if (-s >= 64) mag = 64'd0;
        else mag = v.m >> (-s);
        lim = v.neg ? lim_neg : lim_pos;
        if (over || mag > lim) begin
            mag = lim;
            clip = 1'b1;
        end
        return v.neg ? 64'd0 - mag : mag;
    endfunction

    // exp(t), t in signed Q.28, via 2^k * 2^f with a ten-term series for 2^f
    function automatic mnum_t exp_q28(longint t);
        longint      u;
        longint      whole;
        logic [63:0] f;
        logic [63:0] y;
        logic [63:0] p;
        u = t * longint'(LOG2E_Q28);
        whole = u >>> 56;
        f = 64'(u - (whole <<< 56));
        y = ((f >> 26) * 64'(LN2_Q32)) >> 32;
        p = 64'd1 << 30;
        for (int n = 10; n >= 1; n--)
            p = (64'd1 << 30) + ((p * y) >> 30) / 64'(n);
        return norm(p, int'(whole) - 30, 1'b0);
    endfunction

    function automatic morse_res_t predict_morse(logic [31:0] x, logic [1:0] op);
        morse_res_t  r;
        mnum_t       dn, an, e, e2, v, coef;
        longint      d, t;
        logic [34:0] lim;
        bit          clip;
        r = '{value: 64'd0, sat: 1'b0};
        lim = {cutoff, 4'd0};
        if (op == OP_UNDEF || {3'd0, x} > lim) return r;
        dn = from_fixed(longint'($signed(well_depth)), 24);
        an = from_fixed(longint'($signed(decay_rate)), 24);
        d = longint'($signed(equil_dist)) * 16 - longint'({32'd0, x});
        t = longint'(to_fixed(mul(an, from_fixed(d, 28)), 28, T_LIMIT, T_LIMIT, clip));
        e = exp_q28(t);
        e2 = mul(e, e);
        case (op)
            OP_VALUE: begin
                v = mul(dn, add(e2, negate(twice(e))));
                v = add(v, from_fixed(longint'($signed(offset_const)), 24));
                v = add(v, mul(from_fixed(longint'($signed(offset_slope)), 24),
                               from_fixed(longint'({32'd0, x}), 28)));
            end
            OP_FIRST: begin
                coef = twice(mul(an, dn));
                v = mul(coef, add(e, negate(e2)));
                v = add(v, from_fixed(longint'($signed(offset_slope)), 24));
            end
            default: begin
                coef = twice(mul(mul(an, an), dn));
                v = mul(coef, add(twice(e2), negate(e)));
            end
        endcase
        r.value = to_fixed(v, 40, RES_LIM_POS, RES_LIM_NEG, clip);
        r.sat = clip;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        morse_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0]) sat_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat value %h sat %b", $time,
                         m_tdata, m_tuser[0]);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             want.value, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.sat, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, an idle-free mode, and long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_tready <= 1'b0;
            hold_left <= 300;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // Watchdog: end the run when nothing has moved for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 4000) begin
            $display("Watchdog expired at %0t", $time);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Shared tasks
    // ---------------------------------------------------------------

    // Offer one beat, optionally after a random gap; predict on acceptance
    task automatic send_beat(input logic [31:0] x, input logic [1:0] op);
        if (!tx_steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_morse(x, op));
        beats_sent++;
        if ({3'd0, x} > {cutoff, 4'd0}) beyond_cut++;
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // APB write: setup cycle, access cycle, then back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_WELL_DEPTH:   well_depth = val;
            REG_DECAY_RATE:   decay_rate = val;
            REG_EQUIL_DIST:   equil_dist = val;
            REG_OFFSET_CONST: offset_const = val;
            REG_OFFSET_SLOPE: offset_slope = val;
            default:          cutoff = val[30:0];
        endcase
        reg_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [31:0] dd, input logic [31:0] aa,
                             input logic [31:0] rr, input logic [31:0] q0,
                             input logic [31:0] q1, input logic [31:0] rc);
        drain();
        write_reg(REG_WELL_DEPTH, dd);
        write_reg(REG_DECAY_RATE, aa);
        write_reg(REG_EQUIL_DIST, rr);
        write_reg(REG_OFFSET_CONST, q0);
        write_reg(REG_OFFSET_SLOPE, q1);
        write_reg(REG_CUTOFF, rc);
    endtask

    // Pick a distance that mostly lands inside the cutoff, with boundaries and noise
    function automatic logic [31:0] pick_distance();
        logic [34:0] lim;
        logic [31:0] top;
        logic [31:0] eq;
        lim = {cutoff, 4'd0};
        top = (lim > 35'hFFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0];
        eq = equil_dist << 4;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return $urandom_range(top);
            6:                return eq + 32'($urandom_range(4096)) - 32'd2048;
            7:                return $urandom();
            8:                return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            default:          return top + 32'($urandom_range(2)) - 32'd1;
        endcase
    endfunction

    function automatic logic [1:0] pick_op();
        return ($urandom_range(19) == 0) ? OP_UNDEF : 2'($urandom_range(2));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values: all opcodes at the well; value, first derivative at zero, cutoff
    task automatic test_reset_config;
        logic [31:0] pts[6];
        pts = '{equil_dist << 4, 32'd0, 32'h1000_0000, {cutoff, 4'd0},
                {cutoff, 4'd0} + 32'd1, 32'hFFFF_FFFF};
        foreach (pts[i]) begin
            send_beat(pts[i], OP_VALUE);
            send_beat(pts[i], OP_FIRST);
        end
        send_beat(equil_dist << 4, OP_SECOND);
        send_beat(32'h2000_0000, OP_SECOND);
        send_beat(equil_dist << 4, OP_UNDEF);
    endtask

    // Extreme registers: clamped exponent, saturation both ways, all-zero coefficients
    task automatic test_extreme_config;
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(32'd0, OP_VALUE);
        send_beat(32'd0, OP_FIRST);
        send_beat(32'd0, OP_SECOND);
        send_beat(32'hFFFF_FFFF, OP_VALUE);
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'd0);
        send_beat(32'd0, OP_VALUE);
        send_beat(32'd0, OP_FIRST);
        send_beat(32'd0, OP_SECOND);
        send_beat(32'd1, OP_VALUE);
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_beat(32'h8000_0000, OP_VALUE);
        send_beat(32'h8000_0000, OP_SECOND);
    endtask

    // Random beats over several register settings, each phase drained first
    task automatic test_random_phases;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: write_all(RST_WELL_DEPTH, RST_DECAY_RATE, RST_EQUIL_DIST,
                             RST_OFFSET_CONST, RST_OFFSET_SLOPE, 32'(RST_CUTOFF));
                1: write_all($urandom_range(32'h1000_0000, 32'h0040_0000),
                             $urandom_range(32'h0400_0000, 32'h0080_0000),
                             $urandom_range(32'h0400_0000, 32'h0100_0000),
                             $urandom_range(32'h0200_0000) - 32'h0100_0000,
                             $urandom_range(32'h0200_0000) - 32'h0100_0000,
                             $urandom_range(32'h0800_0000, 32'h0200_0000));
                default: write_all($urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom());
            endcase
            // the second half of the phases runs without idling on either side
            tx_steady = (ph >= 3);
            rx_steady = (ph >= 3);
            repeat (45) send_beat(pick_distance(), pick_op());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure;
        write_all(RST_WELL_DEPTH, RST_DECAY_RATE, RST_EQUIL_DIST,
                  RST_OFFSET_CONST, RST_OFFSET_SLOPE, 32'(RST_CUTOFF));
        hold_asked++;
        tx_steady = 1'b1;
        repeat (100) send_beat(pick_distance(), pick_op());
        tx_steady = 1'b0;
    endtask

    // Sender pauses until the pipeline has emptied, then resumes
    task automatic test_sender_pause;
        for (int b = 0; b < 3; b++) begin
            repeat ($urandom_range(20, 5)) send_beat(pick_distance(), pick_op());
            drain();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 32'd0;
        s_tuser <= OP_VALUE;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 5'd0;
        pwdata <= 32'd0;
        well_depth = RST_WELL_DEPTH;
        decay_rate = RST_DECAY_RATE;
        equil_dist = RST_EQUIL_DIST;
        offset_const = RST_OFFSET_CONST;
        offset_slope = RST_OFFSET_SLOPE;
        cutoff = RST_CUTOFF;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_extreme_config();
        test_random_phases();
        test_backpressure();
        test_sender_pause();

        drain();
        repeat (80) @(posedge aclk);
        $display("Covered %0d beats (%0d past the cutoff), %0d results, %0d clipped,",
                 beats_sent, beyond_cut, results_seen, sat_seen);
        $display("%0d register writes across reset, extreme and random settings.",
                 reg_writes);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mpe_pkg.sv
hdl/mpe_fmul.sv
hdl/mpe_fadd.sv
hdl/morse_pair_potential_eval_core.sv
sim/testbench.sv
